>>> rtl/tvb_pkg.sv
// Shared constants and types for the transformed vertex bounds block.
// No dependencies; imported by the top level and its checker.
package tvb_pkg;

  localparam int unsigned AxisN    = 3;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ColN     = 4;
  localparam int unsigned RowW     = ColN * CoordW;
  localparam int unsigned FracBits = 8;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned SumW     = ProdW + 3;
  localparam int unsigned ShW      = SumW - FracBits;
  localparam int unsigned CfgIdxW  = 2;

  // s_axis tdata: pos x,y,z, seed min x,y,z, seed max x,y,z
  localparam int unsigned InDataW  = 9 * CoordW;
  // m_axis tdata: bound min x,y,z, bound max x,y,z
  localparam int unsigned OutDataW = 6 * CoordW;

  localparam logic [CfgIdxW-1:0] RegRowX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRowY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRowZ = 2'd2;

  localparam logic [RowW-1:0] RowXReset = 64'h0000_0000_0000_0100;
  localparam logic [RowW-1:0] RowYReset = 64'h0000_0000_0100_0000;
  localparam logic [RowW-1:0] RowZReset = 64'h0000_0100_0000_0000;

  localparam logic signed [CoordW-1:0] CoordMax = 16'sh7FFF;
  localparam logic signed [CoordW-1:0] CoordMin = -16'sh8000;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic   first;
    logic   last;
    coord_t seed_min_x;
    coord_t seed_min_y;
    coord_t seed_min_z;
    coord_t seed_max_x;
    coord_t seed_max_y;
    coord_t seed_max_z;
  } side_t;

endpackage

>>> rtl/transformed_vertex_bounds.sv
// Transformed vertex bounds: top level, affine transform plus min/max fold.
// Depends on tvb_pkg.
//
// Each request carries one Q8.8 vertex; it is multiplied by the three
// configured matrix rows (w = 1), floor-shifted back to Q8.8, saturated
// and folded into running per-axis min/max bounds, which are returned with
// tlast echoed. Throughput is one vertex per cycle while the output is not
// stalled; the vertex passes the input register, product register, sum and
// saturate register, then folds into the output register. The fold against
// the running bounds is the only loop. tuser set on a request reloads the
// bounds from its seed fields before the fold. Matrix rows are written on
// the cfg channel, which is always ready; write it only while no request
// is in flight.
module transformed_vertex_bounds (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tvb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tvb_pkg::RowW-1:0]        cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, pos_z, seed_min_x/y/z, seed_max_x/y/z (16 bits each)
  input  logic [tvb_pkg::InDataW-1:0]     s_axis_tdata,
  // first
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bound_min_x/y/z, bound_max_x/y/z (16 bits each)
  output logic [tvb_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast
);
  import tvb_pkg::*;

  logic [RowW-1:0] row_q [AxisN];

  logic   v1_q, v2_q, v3_q, out_v_q;
  logic   out_rdy, r3, r2, r1;
  coord_t pos_q [AxisN];
  side_t  side1_q, side2_q, side3_q;

  logic signed [ProdW-1:0]  prod_q  [AxisN][AxisN];
  coord_t                   trans_q [AxisN];
  logic signed [SumW-1:0]   sum     [AxisN];
  logic signed [ShW-1:0]    shifted [AxisN];
  coord_t                   w_d     [AxisN];
  coord_t                   w_q     [AxisN];

  coord_t run_min_q [AxisN];
  coord_t run_max_q [AxisN];
  coord_t seed_min  [AxisN];
  coord_t seed_max  [AxisN];
  coord_t base_min  [AxisN];
  coord_t base_max  [AxisN];
  coord_t new_min   [AxisN];
  coord_t new_max   [AxisN];
  coord_t out_min_q [AxisN];
  coord_t out_max_q [AxisN];
  logic   out_last_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RowXReset;
      row_q[1] <= RowYReset;
      row_q[2] <= RowZReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRowX: row_q[0] <= cfg_data_i;
        RegRowY: row_q[1] <= cfg_data_i;
        RegRowZ: row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage ready chain
  assign out_rdy       = !out_v_q || m_axis_tready;
  assign r3            = !v3_q || out_rdy;
  assign r2            = !v2_q || r3;
  assign r1            = !v1_q || r2;
  assign s_axis_tready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r1)      v1_q    <= s_axis_tvalid;
      if (r2)      v2_q    <= v1_q;
      if (r3)      v3_q    <= v2_q;
      if (out_rdy) out_v_q <= v3_q;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && r1) begin
      for (int a = 0; a < AxisN; a++) begin
        pos_q[a] <= s_axis_tdata[a*CoordW +: CoordW];
      end
      side1_q.first      <= s_axis_tuser;
      side1_q.last       <= s_axis_tlast;
      side1_q.seed_min_x <= s_axis_tdata[3*CoordW +: CoordW];
      side1_q.seed_min_y <= s_axis_tdata[4*CoordW +: CoordW];
      side1_q.seed_min_z <= s_axis_tdata[5*CoordW +: CoordW];
      side1_q.seed_max_x <= s_axis_tdata[6*CoordW +: CoordW];
      side1_q.seed_max_y <= s_axis_tdata[7*CoordW +: CoordW];
      side1_q.seed_max_z <= s_axis_tdata[8*CoordW +: CoordW];
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (v1_q && r2) begin
      for (int r = 0; r < AxisN; r++) begin
        for (int c = 0; c < AxisN; c++) begin
          prod_q[r][c] <= $signed(row_q[r][c*CoordW +: CoordW]) * pos_q[c];
        end
        trans_q[r] <= $signed(row_q[r][AxisN*CoordW +: CoordW]);
      end
      side2_q <= side1_q;
    end
  end

  // stage 3: sum, floor shift, saturate
  always_comb begin
    for (int r = 0; r < AxisN; r++) begin
      sum[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2])
             + (SumW'(trans_q[r]) <<< FracBits);
      shifted[r] = sum[r][SumW-1:FracBits];
      if (shifted[r] > ShW'(CoordMax)) begin
        w_d[r] = CoordMax;
      end else if (shifted[r] < ShW'(CoordMin)) begin
        w_d[r] = CoordMin;
      end else begin
        w_d[r] = shifted[r][CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      w_q     <= w_d;
      side3_q <= side2_q;
    end
  end

  // stage 4: fold into running bounds
  assign seed_min[0] = side3_q.seed_min_x;
  assign seed_min[1] = side3_q.seed_min_y;
  assign seed_min[2] = side3_q.seed_min_z;
  assign seed_max[0] = side3_q.seed_max_x;
  assign seed_max[1] = side3_q.seed_max_y;
  assign seed_max[2] = side3_q.seed_max_z;

  always_comb begin
    for (int a = 0; a < AxisN; a++) begin
      base_min[a] = side3_q.first ? seed_min[a] : run_min_q[a];
      base_max[a] = side3_q.first ? seed_max[a] : run_max_q[a];
      new_min[a]  = (w_q[a] < base_min[a]) ? w_q[a] : base_min[a];
      new_max[a]  = (w_q[a] > base_max[a]) ? w_q[a] : base_max[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AxisN; a++) begin
        run_min_q[a] <= CoordMax;
        run_max_q[a] <= CoordMin;
      end
    end else if (v3_q && out_rdy) begin
      run_min_q <= new_min;
      run_max_q <= new_max;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && out_rdy) begin
      out_min_q  <= new_min;
      out_max_q  <= new_max;
      out_last_q <= side3_q.last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_max_q[2], out_max_q[1], out_max_q[0],
                          out_min_q[2], out_min_q[1], out_min_q[0]};

endmodule

>>> rtl/tvb_checker.sv
// Port-level checker for transformed_vertex_bounds, attached by bind.
// Depends on tvb_pkg.
module tvb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tvb_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic                            m_axis_tlast
);
  import tvb_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // empty output register never blocks the input
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a result being taken frees the input side
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while result taken");

  // no result appears from a drained pipeline
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(s_acc, 1) && !$past(s_acc, 2) && !$past(s_acc, 3) && !$past(s_acc, 4) &&
    !$past(m_axis_tvalid, 1) && !$past(m_axis_tvalid, 2) &&
    !$past(m_axis_tvalid, 3) |-> !m_axis_tvalid)
    else $error("result without request");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind transformed_vertex_bounds tvb_checker u_tvb_checker (.*);
